// ===== src/fta_pkg.sv =====
// Shared types and constants for the frame-time moving average block.
`default_nettype none

package fta_pkg;

  localparam int DUR_W = 24;
  localparam int CFG_W = 8;
  localparam logic [CFG_W-1:0] RESET_WINDOW = 8'd90;
  localparam logic [DUR_W-1:0] DUR_MAX = 24'hFF_FFFF;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_UPDATE,
    ST_DIV,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic clear;
    logic accept;
    logic update;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic div_done;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

// ===== src/fta_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module fta_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ===== src/fta_div.sv =====
// Restoring divider, one quotient bit per cycle.
`default_nettype none

module fta_div #(
  parameter int DIVIDEND_W = 31,
  parameter int DIVISOR_W  = 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic [DIVIDEND_W-1:0] dividend,
  input  wire logic [DIVISOR_W-1:0]  divisor,
  output logic                       done,
  output logic      [DIVIDEND_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DIVIDEND_W + 1);

  logic [CNT_W-1:0]     cnt;
  logic [DIVISOR_W-1:0] dvs;
  logic [DIVISOR_W-1:0] rem;
  logic [DIVISOR_W:0]   partial;
  logic [DIVISOR_W:0]   diff;
  logic                 ge;

  assign partial = {rem, quotient[DIVIDEND_W-1]};
  assign ge      = partial >= {1'b0, dvs};
  assign diff    = partial - {1'b0, dvs};
  assign done    = (cnt == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CNT_W'(DIVIDEND_W);
    end else if (!done) begin
      cnt <= cnt - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvs      <= divisor;
      rem      <= '0;
      quotient <= dividend;
    end else if (!done) begin
      rem      <= ge ? diff[DIVISOR_W-1:0] : partial[DIVISOR_W-1:0];
      quotient <= {quotient[DIVIDEND_W-2:0], ge};
    end
  end

endmodule

`default_nettype wire

// ===== src/fta_datapath.sv =====
// Datapath: window register, sample ring, running sum, divider and output word.
`default_nettype none

module fta_datapath #(
  parameter int MAX_WINDOW = 128
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire fta_pkg::cmd_t              cmd,
  output fta_pkg::status_t                status,
  input  wire logic                       window_size_wr,
  input  wire logic [fta_pkg::CFG_W-1:0]  window_size,
  input  wire logic [fta_pkg::DUR_W-1:0]  frame_duration,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic      [fta_pkg::DUR_W-1:0]  average_duration,
  output logic                            window_full
);

  localparam int IDX_W = $clog2(MAX_WINDOW);
  localparam int DV_W  = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W = fta_pkg::DUR_W + $clog2(MAX_WINDOW);
  localparam int CMP_W = (DV_W > fta_pkg::CFG_W) ? DV_W : fta_pkg::CFG_W;

  logic [fta_pkg::CFG_W-1:0] window_cfg;
  logic [DV_W-1:0]           size;
  logic [IDX_W-1:0]          write_index;
  logic [IDX_W-1:0]          idx_sel;
  logic [IDX_W-1:0]          idx;
  logic [DV_W-1:0]           idx_p1;
  logic [fta_pkg::DUR_W-1:0] dur;
  logic [SUM_W-1:0]          running_sum;
  logic [SUM_W-1:0]          sum_next;
  logic                      warming_up;
  logic                      warming_next;
  logic [DV_W-1:0]           divisor;
  logic [IDX_W-1:0]          clr_cnt;
  logic                      ram_we;
  logic [IDX_W-1:0]          ram_waddr;
  logic [fta_pkg::DUR_W-1:0] ram_wdata;
  logic [fta_pkg::DUR_W-1:0] old_dur;
  logic                      div_done;
  logic [SUM_W-1:0]          quotient;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_cfg <= fta_pkg::RESET_WINDOW;
    end else if (window_size_wr) begin
      window_cfg <= window_size;
    end
  end

  always_comb begin
    if (window_cfg == '0) begin
      size = DV_W'(1);
    end else if (CMP_W'(window_cfg) > CMP_W'(MAX_WINDOW)) begin
      size = DV_W'(MAX_WINDOW);
    end else begin
      size = DV_W'(window_cfg);
    end
  end

  assign idx_sel      = (DV_W'(write_index) >= size) ? '0 : write_index;
  assign idx_p1       = DV_W'(idx) + DV_W'(1);
  assign sum_next     = running_sum - SUM_W'(old_dur) + SUM_W'(dur);
  assign warming_next = warming_up && (idx_p1 != size);
  assign divisor      = warming_next ? idx_p1 : size;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      dur <= frame_duration;
      idx <= idx_sel;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum <= '0;
      write_index <= '0;
      warming_up  <= 1'b1;
    end else if (cmd.update) begin
      running_sum <= sum_next;
      warming_up  <= warming_next;
      write_index <= (idx_p1 >= size) ? '0 : IDX_W'(idx_p1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clear) begin
      clr_cnt <= clr_cnt + IDX_W'(1);
    end
  end

  assign ram_we    = cmd.clear || cmd.update;
  assign ram_waddr = cmd.clear ? clr_cnt : idx;
  assign ram_wdata = cmd.clear ? '0 : dur;

  fta_ram #(
    .WIDTH (fta_pkg::DUR_W),
    .DEPTH (MAX_WINDOW)
  ) u_ring (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (idx),
    .rd_data (old_dur)
  );

  fta_div #(
    .DIVIDEND_W (SUM_W),
    .DIVISOR_W  (DV_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.update),
    .dividend (sum_next),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      window_full <= 1'b0;
    end else if (cmd.load) begin
      out_valid   <= 1'b1;
      window_full <= !warming_up;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      average_duration <= (quotient[SUM_W-1:fta_pkg::DUR_W] != '0) ?
                          fta_pkg::DUR_MAX : quotient[fta_pkg::DUR_W-1:0];
    end
  end

  assign status.clear_last = (clr_cnt == IDX_W'(MAX_WINDOW - 1));
  assign status.div_done   = div_done;
  assign status.out_free   = !out_valid || !out_stall;

endmodule

`default_nettype wire

// ===== src/fta_ctrl.sv =====
// Controller: sequences clearing pass, ring read, update, divide and output load.
`default_nettype none

module fta_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire fta_pkg::status_t  status,
  output fta_pkg::cmd_t          cmd
);

  fta_pkg::state_t state;
  fta_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fta_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      fta_pkg::ST_CLEAR: begin
        if (status.clear_last) state_next = fta_pkg::ST_IDLE;
      end
      fta_pkg::ST_IDLE: begin
        if (in_valid) state_next = fta_pkg::ST_READ;
      end
      fta_pkg::ST_READ:   state_next = fta_pkg::ST_UPDATE;
      fta_pkg::ST_UPDATE: state_next = fta_pkg::ST_DIV;
      fta_pkg::ST_DIV: begin
        if (status.div_done) state_next = fta_pkg::ST_OUT;
      end
      fta_pkg::ST_OUT: begin
        if (status.out_free) state_next = fta_pkg::ST_IDLE;
      end
      default: state_next = fta_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state)
      fta_pkg::ST_CLEAR:  cmd.clear = 1'b1;
      fta_pkg::ST_IDLE: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
      end
      fta_pkg::ST_READ:   ;
      fta_pkg::ST_UPDATE: cmd.update = 1'b1;
      fta_pkg::ST_DIV:    ;
      fta_pkg::ST_OUT:    cmd.load = status.out_free;
      default:            ;
    endcase
  end

endmodule

`default_nettype wire

// ===== src/frame_time_moving_average_core.sv =====
// Top level of the frame-time moving average block.
//
// Input channel: frame_duration words (unsigned microseconds) on in_valid /
// in_stall. Output channel: average_duration and window_full on out_valid /
// out_stall. window_size is loaded whenever window_size_wr is high.
//
// Each word runs through one ring read, one sum update and a bit-serial
// restoring divide of the running sum (24 + log2(MAX_WINDOW) steps, 31 at the
// default size). The result is then loaded into the output register, and the
// next word can be taken in the cycle after the result is loaded, so the block
// does not take a new word before it is through with the last.
//
// After reset the block walks the ring once to zero it, holding in_stall high;
// window_size returns to 90. While the receiver stalls, the result holds in
// the output register; the block finishes the next word's divide and then
// waits for the register to free up.
`default_nettype none

module frame_time_moving_average_core #(
  parameter int MAX_WINDOW = 128
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      window_size_wr,
  input  wire logic [fta_pkg::CFG_W-1:0] window_size,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic [fta_pkg::DUR_W-1:0] frame_duration,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic      [fta_pkg::DUR_W-1:0] average_duration,
  output logic                           window_full
);

  fta_pkg::cmd_t    cmd;
  fta_pkg::status_t status;

  fta_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  fta_datapath #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .status           (status),
    .window_size_wr   (window_size_wr),
    .window_size      (window_size),
    .frame_duration   (frame_duration),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .average_duration (average_duration),
    .window_full      (window_full)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken again right after an accept");

  a_clear_after_reset: assert property (@(posedge clk)
    rst |=> in_stall)
    else $error("input open during clearing pass");

  a_full_sticky: assert property (@(posedge clk) disable iff (rst)
    !$fell(window_full))
    else $error("window_full dropped without reset");

  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.clear, cmd.accept, cmd.update, cmd.load}))
    else $error("overlapping datapath commands");

endmodule

`default_nettype wire
